// ===== design/mss_pkg.sv =====
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and constants of the masked signature scanner.
// ----------------------------------------------------------------------------
package mss_pkg;

    localparam int MAX_PATTERN_DEF = 128;
    localparam int OFFSET_BITS_DEF = 24;

    localparam int PAT_IDX_W  = 7;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 8;
    localparam int OUT_OFS_W  = 24;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 32;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SCAN = 1'b1;

    // Broadcast control from the front end to every cell of the chain.
    typedef struct packed {
        logic              load;
        logic              shift;
        logic              clear;
        logic              step;
        logic              care;
        logic [BYTE_W-1:0] data_byte;
    } t_cell_ctrl;

endpackage

// ===== design/masked_signature_scanner.sv =====
// ----------------------------------------------------------------------------
// masked_signature_scanner
// Wildcard byte pattern search: a chain of cells keeps every partial match.
// Throughput: one request per cycle, loads and scans alike, unless the result
// stage stalls, set by the cell chain advancing all partial match bits together.
// Result path: a final image byte passes the result stage, then the output register.
// Reset: synchronous, active low; clears scan state and sets length to one.
// ----------------------------------------------------------------------------
module masked_signature_scanner
    import mss_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // pattern_index[6:0], data_byte[14:7], care[15]
    input  logic                 s_axis_tuser,  // command
    input  logic                 s_axis_tlast,  // last_byte
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // found[0], match_offset[24:1], overflow[25]
    // pattern length register
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [LEN_W-1:0]     i_cfg_data
);

    localparam int IW = $clog2(MAX_PATTERN);

    // Unpack the request.
    logic [PAT_IDX_W-1:0] w_idx;
    logic [BYTE_W-1:0]    w_byte;
    logic                 w_care;
    assign w_idx  = s_axis_tdata[PAT_IDX_W-1:0];
    assign w_byte = s_axis_tdata[PAT_IDX_W+BYTE_W-1:PAT_IDX_W];
    assign w_care = s_axis_tdata[PAT_IDX_W+BYTE_W];

    // ------------------------------------------------------------------
    // Pattern length: fold out-of-range values into 1..MAX_PATTERN and
    // hold it as the index of the tap cell.
    // ------------------------------------------------------------------
    logic [IW-1:0]    r_len_m1;
    logic [IW-1:0]    n_len_m1;
    logic [LEN_W-1:0] w_cfg_dec;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_dec   = i_cfg_data - LEN_W'(1);

    always_comb begin
        priority if (i_cfg_data == '0) begin
            n_len_m1 = '0;
        end else if ({1'b0, i_cfg_data} > (LEN_W+1)'(MAX_PATTERN)) begin
            n_len_m1 = IW'(MAX_PATTERN - 1);
        end else begin
            n_len_m1 = w_cfg_dec[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_m1 <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_len_m1 <= n_len_m1;
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The result stage stalls only when it holds a final byte
    // and the output register is still occupied.
    // ------------------------------------------------------------------
    logic r_b_valid;
    logic r_b_last;
    logic r_o_valid;
    logic w_stall;
    logic w_acc;
    logic w_scan;
    logic w_load;

    assign w_stall       = r_b_valid & r_b_last & r_o_valid & ~m_axis_tready;
    assign s_axis_tready = ~w_stall;
    assign w_acc         = s_axis_tvalid & s_axis_tready;
    assign w_scan        = w_acc & (s_axis_tuser == CMD_SCAN);
    assign w_load        = w_acc & (s_axis_tuser == CMD_LOAD);

    // ------------------------------------------------------------------
    // Front end: image position and overflow tracking.
    // ------------------------------------------------------------------
    logic [OFFSET_BITS-1:0] r_pos;
    logic                   r_ovf;
    logic                   w_pos_max;
    logic                   w_shift;
    logic                   w_ovf_next;

    assign w_pos_max  = &r_pos;
    assign w_shift    = w_scan & ~r_ovf & ~w_pos_max;
    assign w_ovf_next = r_ovf | w_pos_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ovf <= 1'b0;
        end else if (w_scan) begin
            if (s_axis_tlast) begin
                // End of image: restart the offset count.
                r_pos <= '0;
                r_ovf <= 1'b0;
            end else if (w_shift) begin
                r_pos <= r_pos + OFFSET_BITS'(1);
            end else begin
                r_ovf <= w_ovf_next;
            end
        end
    end

    // Drop loads that point past the chain.
    logic [IW-1:0]          w_sel_idx;
    logic                   w_idx_ok;
    logic [PAT_IDX_W+1:0]   w_idx_wide;
    assign w_idx_wide = {2'b00, w_idx};
    assign w_idx_ok   = w_idx_wide < (PAT_IDX_W+2)'(MAX_PATTERN);
    assign w_sel_idx  = w_idx_wide[IW-1:0];

    t_cell_ctrl w_ctrl;
    always_comb begin
        w_ctrl.load      = w_load & w_idx_ok;
        w_ctrl.shift     = w_shift;
        w_ctrl.clear     = w_scan & s_axis_tlast;
        w_ctrl.step      = ~w_stall;
        w_ctrl.care      = w_care;
        w_ctrl.data_byte = w_byte;
    end

    // ------------------------------------------------------------------
    // Cell chain: cell i holds the partial match over entries 0..i and
    // hands it right each scanned byte before overflow. Only the tap cell reports a hit.
    // ------------------------------------------------------------------
    logic [MAX_PATTERN-1:0] w_part;
    logic [MAX_PATTERN-1:0] w_prev;
    logic [MAX_PATTERN-1:0] w_hit;

    assign w_prev = {w_part[MAX_PATTERN-2:0], 1'b1};

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        mss_cell #(
            .IDX (g),
            .IW  (IW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_sel_idx (w_sel_idx),
            .i_len_m1  (r_len_m1),
            .i_prev    (w_prev[g]),
            .o_part    (w_part[g]),
            .o_hit     (w_hit[g])
        );
    end

    // ------------------------------------------------------------------
    // Result stage: hold the byte's bookkeeping next to the cells' hit.
    // ------------------------------------------------------------------
    logic                   r_b_ovf;
    logic [OFFSET_BITS-1:0] r_b_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_last  <= 1'b0;
        end else if (!w_stall) begin
            r_b_valid <= w_scan;
            r_b_last  <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall) begin
            r_b_ovf   <= w_ovf_next;
            // Start of a match that ends at this byte.
            r_b_start <= r_pos - OFFSET_BITS'(r_len_m1);
        end
    end

    logic                   w_hit_any;
    logic                   w_proc;
    logic                   r_seen;
    logic                   r_sev;
    logic [OFFSET_BITS-1:0] r_first;
    logic                   w_found;
    logic [OFFSET_BITS-1:0] w_ofs_sel;
    logic [OUT_OFS_W-1:0]   w_ofs_out;

    assign w_hit_any = |w_hit;
    assign w_proc    = r_b_valid & ~w_stall;
    assign w_found   = ~r_b_ovf & (r_seen | w_hit_any) & ~r_sev & ~(r_seen & w_hit_any);
    assign w_ofs_sel = r_seen ? r_first : r_b_start;

    if (OFFSET_BITS >= OUT_OFS_W) begin : g_ofs_trunc
        assign w_ofs_out = w_ofs_sel[OUT_OFS_W-1:0];
    end else begin : g_ofs_ext
        assign w_ofs_out = {{(OUT_OFS_W-OFFSET_BITS){1'b0}}, w_ofs_sel};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 1'b0;
            r_sev   <= 1'b0;
            r_first <= '0;
        end else if (w_proc) begin
            if (r_b_last) begin
                r_seen  <= 1'b0;
                r_sev   <= 1'b0;
                r_first <= '0;
            end else if (w_hit_any) begin
                if (r_seen) begin
                    r_sev <= 1'b1;
                end else begin
                    r_seen  <= 1'b1;
                    r_first <= r_b_start;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic                 r_o_found;
    logic                 r_o_ovf;
    logic [OUT_OFS_W-1:0] r_o_ofs;
    logic                 w_emit;

    assign w_emit = w_proc & r_b_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_emit) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_found <= w_found;
            r_o_ovf   <= r_b_ovf;
            r_o_ofs   <= w_found ? w_ofs_out : '0;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {{(M_TDATA_W-OUT_OFS_W-2){1'b0}}, r_o_ovf, r_o_ofs, r_o_found};

endmodule

// ===== design/mss_cell.sv =====
// ----------------------------------------------------------------------------
// mss_cell
// One pattern position: stored byte and care bit, partial match bit, tap.
// ----------------------------------------------------------------------------
module mss_cell
    import mss_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IW  = 7
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic [IW-1:0] i_sel_idx,
    input  logic [IW-1:0] i_len_m1,
    input  logic       i_prev,
    output logic       o_part,
    output logic       o_hit
);

    logic [BYTE_W-1:0] r_byte;
    logic              r_care;
    logic              r_part;
    logic              r_hit;
    logic              n_part;
    logic              w_here;

    assign w_here = (i_sel_idx == IW'(IDX));
    // Extend the run from the left neighbor when this entry accepts the byte.
    assign n_part = i_prev & (~r_care | (r_byte == i_ctrl.data_byte));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && w_here) begin
            r_byte <= i_ctrl.data_byte;
            r_care <= i_ctrl.care;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            if (i_ctrl.clear) begin
                r_part <= 1'b0;
            end else if (i_ctrl.shift) begin
                r_part <= n_part;
            end
            if (i_ctrl.step) begin
                r_hit <= i_ctrl.shift & n_part & (i_len_m1 == IW'(IDX));
            end
        end
    end

    assign o_part = r_part;
    assign o_hit  = r_hit;

endmodule
